[rtl/tlphl_pkg.sv]
// Types, constants and reduction function for the two-level perfect hash lookup.
package tlphl_pkg;

  localparam int BUCKETS = 256;
  localparam int CELLS   = 4096;
  localparam int BKT_AW  = $clog2(BUCKETS);
  localparam int CELL_AW = $clog2(CELLS);

  localparam int KEY_W  = 31;
  localparam int SLOT_W = 12;
  localparam int SIZE_W = 13;
  localparam int BASE_W = 12;
  localparam int CNT_W  = 9;
  localparam int IDX_W  = 3;
  localparam int PROD_W = 2 * KEY_W;
  localparam int VAL_W  = 64;
  localparam int CELL_W = KEY_W + 1;

  localparam int STEPS = 4;
  localparam int RED   = VAL_W / STEPS;

  localparam int S_MUL1 = 1;
  localparam int S_P1   = S_MUL1 + RED;
  localparam int S_FIX1 = S_P1 + 1;
  localparam int S_M    = S_FIX1 + RED;
  localparam int S_BKT  = S_M + 1;
  localparam int S_BRD  = S_BKT + 1;
  localparam int S_MUL2 = S_BRD + 1;
  localparam int S_P2   = S_MUL2 + RED;
  localparam int S_FIX2 = S_P2 + 1;
  localparam int S_Z    = S_FIX2 + RED;
  localparam int S_CELL = S_Z + 1;
  localparam int S_LAST = S_CELL + 1;

  typedef enum logic [1:0] {
    ACT_WR_BUCKET = 2'd0,
    ACT_WR_CELL   = 2'd1,
    ACT_QUERY     = 2'd2,
    ACT_NONE      = 2'd3
  } act_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PRIME  = 3'd0,
    REG_TOPMUL = 3'd1,
    REG_TOPADD = 3'd2,
    REG_BCOUNT = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0]  mul;
    logic [KEY_W-1:0]  add;
    logic [SIZE_W-1:0] size;
    logic [BASE_W-1:0] base;
  } bent_t;

  typedef struct packed {
    logic               vld;
    logic [1:0]         act;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   smul;
    logic [KEY_W-1:0]   sadd;
    logic [SIZE_W-1:0]  ssize;
    logic [BASE_W-1:0]  sbase;
    logic               miss;
    logic [PROD_W-1:0]  prod;
    logic [VAL_W-1:0]   val;
    logic [KEY_W-1:0]   rem;
    logic [KEY_W-1:0]   bmul;
    logic [KEY_W-1:0]   badd;
    logic [SIZE_W-1:0]  bsize;
    logic [BASE_W-1:0]  bbase;
    logic [BKT_AW-1:0]  bkt;
    logic [CELL_AW-1:0] caddr;
  } item_t;

  function automatic item_t red(item_t it, logic [KEY_W-1:0] d);
    logic [KEY_W:0] t;
    item_t o;
    o = it;
    for (int s = 0; s < STEPS; s++) begin
      t = {o.rem, o.val[VAL_W-1]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      o.rem = t[KEY_W-1:0];
      o.val = {o.val[VAL_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/two_level_perfect_hash_lookup.sv]
// Two-level perfect hash lookup engine: pipelined hashing around bucket and cell memories.
//
// Input words enter on start when busy is low: action 0 writes a bucket descriptor,
// action 1 writes a cell key, action 2 queries a key. One word is taken every cycle.
// Each word runs through a fixed pipeline of S_LAST+1 (73) stages: a top hash
// multiply, two bit-serial reductions (mod prime, mod bucket count, four bits a
// stage), the bucket memory, a second multiply and two more reductions (mod prime,
// mod bucket size), then the cell memory. Writes travel the same pipeline and
// land in their memory at the stage where queries read it, so order is kept.
// A query gives one result when it leaves the last stage: done pulses for one cycle
// with found. Other actions give no result. The receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready (ready always high); the user must make
// them only while no word is in flight, which the block itself does not enforce.
// Reset clears the pipeline and the bucket valid bits and sets the registers to their
// defaults, then sweeps the cell memory to the empty marker one cell a cycle: busy
// stays high until the sweep has written the last cell.
module two_level_perfect_hash_lookup import tlphl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [SLOT_W-1:0]   slot_index,
  input  logic [KEY_W-1:0]    key,
  input  logic [KEY_W-1:0]    sec_multiplier,
  input  logic [KEY_W-1:0]    sec_addend,
  input  logic [SIZE_W-1:0]   sec_size,
  input  logic [BASE_W-1:0]   sec_base,
  output logic                done,
  output logic                found,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [KEY_W-1:0]    cfg_data
);

  logic [KEY_W-1:0] prime_modulus;
  logic [KEY_W-1:0] top_multiplier;
  logic [KEY_W-1:0] top_addend;
  logic [CNT_W-1:0] bucket_count;

  item_t pipe [S_LAST+1];
  item_t nxt  [S_LAST+1];

  bent_t               bmem [BUCKETS];
  logic [BUCKETS-1:0]  bvalid;
  bent_t               brd;
  logic                brd_v;
  logic [CELL_W-1:0]   cmem [CELLS];
  logic [CELL_W-1:0]   crd;

  logic               clearing;
  logic [CELL_AW-1:0] clr_addr;

  assign busy      = clearing;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus  <= 31'h7FFFFFFF;
      top_multiplier <= 31'd1;
      top_addend     <= 31'd0;
      bucket_count   <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRIME:  prime_modulus  <= cfg_data;
        REG_TOPMUL: top_multiplier <= cfg_data;
        REG_TOPADD: top_addend     <= cfg_data;
        REG_BCOUNT: bucket_count   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item_t p;
    logic [PROD_W-1:0] x;
    logic [SIZE_W:0] csum;
    nxt[0]       = '0;
    nxt[0].vld   = start && !busy;
    nxt[0].act   = action;
    nxt[0].slot  = slot_index;
    nxt[0].key   = key;
    nxt[0].smul  = sec_multiplier;
    nxt[0].sadd  = sec_addend;
    nxt[0].ssize = sec_size;
    nxt[0].sbase = sec_base;
    for (int i = 1; i <= S_LAST; i++) begin
      p = pipe[i-1];
      x = '0;
      csum = '0;
      if (i == S_MUL1 || i == S_MUL2) begin
        if (i == S_MUL2) begin
          p.bmul  = brd.mul;
          p.badd  = brd.add;
          p.bbase = brd.base;
          p.bsize = brd_v ? brd.size : '0;
          p.miss  = p.miss || !brd_v || (brd.size == '0);
          p.prod  = PROD_W'(p.bmul) * PROD_W'(p.key) + PROD_W'(p.badd);
        end else begin
          p.prod = PROD_W'(top_multiplier) * PROD_W'(p.key) + PROD_W'(top_addend);
        end
        p.val = VAL_W'(p.prod);
        p.rem = '0;
      end else if ((i > S_MUL1 && i <= S_P1) || (i > S_MUL2 && i <= S_P2)) begin
        p = red(p, prime_modulus);
      end else if (i == S_FIX1 || i == S_FIX2) begin
        x = (prime_modulus == '0) ? p.prod : PROD_W'(p.rem);
        p.val = VAL_W'(x);
        p.rem = '0;
      end else if (i > S_FIX1 && i <= S_M) begin
        p = red(p, KEY_W'(bucket_count));
      end else if (i > S_FIX2 && i <= S_Z) begin
        p = red(p, KEY_W'(p.bsize));
      end else if (i == S_BKT) begin
        p.miss = (bucket_count == '0) || (32'(p.rem) >= 32'(BUCKETS));
        p.bkt  = BKT_AW'(p.rem);
      end else if (i == S_CELL) begin
        csum    = (SIZE_W+1)'(p.bbase) + (SIZE_W+1)'(p.rem[SIZE_W-1:0]);
        p.miss  = p.miss || (32'(csum) >= 32'(CELLS));
        p.caddr = CELL_AW'(csum);
      end
      nxt[i] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= S_LAST; i++) begin
        pipe[i].vld <= 1'b0;
      end
    end else begin
      pipe <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (pipe[S_BKT].vld && pipe[S_BKT].act == ACT_WR_BUCKET &&
                 32'(pipe[S_BKT].slot) < 32'(BUCKETS)) begin
      bvalid[BKT_AW'(pipe[S_BKT].slot)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe[S_BKT].vld && pipe[S_BKT].act == ACT_WR_BUCKET &&
        32'(pipe[S_BKT].slot) < 32'(BUCKETS)) begin
      bmem[BKT_AW'(pipe[S_BKT].slot)] <= '{mul: pipe[S_BKT].smul, add: pipe[S_BKT].sadd,
                                           size: pipe[S_BKT].ssize,
                                           base: pipe[S_BKT].sbase};
    end
    brd   <= bmem[pipe[S_BKT].bkt];
    brd_v <= bvalid[pipe[S_BKT].bkt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == CELL_AW'(CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      cmem[clr_addr] <= '1;
    end else if (pipe[S_CELL].vld && pipe[S_CELL].act == ACT_WR_CELL &&
                 32'(pipe[S_CELL].slot) < 32'(CELLS)) begin
      cmem[CELL_AW'(pipe[S_CELL].slot)] <= {1'b0, pipe[S_CELL].key};
    end
    crd <= cmem[pipe[S_CELL].caddr];
  end

  assign done  = pipe[S_LAST].vld && pipe[S_LAST].act == ACT_QUERY;
  assign found = done && !pipe[S_LAST].miss && (crd == {1'b0, pipe[S_LAST].key});

endmodule

[rtl/tlphl_checker.sv]
// Port-level assertions for the two-level perfect hash lookup, with its bind.
module tlphl_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic found,
  input logic cfg_ready
);

  a_found_with_done: assert property (@(posedge clk) disable iff (rst) found |-> done)
    else $error("found without done");

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  a_no_done_after_busy: assert property (@(posedge clk) $past(busy) |-> !done)
    else $error("result while clearing");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind two_level_perfect_hash_lookup tlphl_checker u_tlphl_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .found(found), .cfg_ready(cfg_ready)
);
